// ===== rtl/core/huffman_code_builder_core_macros.svh =====
// Assertion macros used by the checker file of the code builder.
`ifndef HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH

// Clocked assertion, off while reset is held.
`define HCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define HCB_ASSERT_NEVER(label, cond, msg) \
  `HCB_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/hcb_pkg.sv =====
// Shared types and constants of the code builder.
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;

  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned CODE_W    = 64;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 96;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_HFY_RD,
    ST_HFY_X,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_POP_RD,
    ST_POP_X,
    ST_PUSH,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_X,
    ST_WALK_DEC,
    ST_WALK_CHILD,
    ST_WALK_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CTX_HFY,
    CTX_POPA,
    CTX_POPB
  } ctx_e;

  typedef struct packed {
    logic load;
    logic build;
    logic hfy_rd;
    logic hfy_x;
    logic hfy_dec;
    logic sift_rd;
    logic sift_cmp;
    logic pop_rd;
    logic pop_x;
    logic pop_second;
    logic push;
    logic up_rd;
    logic up_cmp;
    logic root_rd;
    logic root_x;
    logic walk_child;
    logic walk_emit;
  } cmd_t;

  typedef struct packed {
    logic hfy_zero;
    logic fill_gt1;
    logic sift_stop;
    logic up_zero;
    logic up_stop;
    logic is_leaf;
    logic sp_zero;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/hcb_ram.sv =====
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/hcb_ctrl.sv =====
// Sequencer for load, heap build, merges and tree walk.
`timescale 1ns / 1ps
`default_nettype none
module hcb_ctrl import hcb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_accept_i,
  input  wire logic in_last_i,
  input  wire sts_t sts_i,
  output logic      in_ready_o,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;
  state_e after_merge;

  assign after_merge = sts_i.fill_gt1 ? ST_POP_RD : ST_ROOT_RD;

  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept_i && in_last_i) begin
          state_d = ST_HFY_RD;
          ctx_d   = CTX_HFY;
        end
      end
      ST_HFY_RD:  state_d = ST_HFY_X;
      ST_HFY_X:   state_d = ST_SIFT_RD;
      ST_SIFT_RD: state_d = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        if (!sts_i.sift_stop) begin
          state_d = ST_SIFT_RD;
        end else begin
          case (ctx_q)
            CTX_HFY: begin
              if (sts_i.hfy_zero) begin
                state_d = after_merge;
                ctx_d   = CTX_POPA;
              end else begin
                state_d = ST_HFY_RD;
              end
            end
            CTX_POPA: begin
              state_d = ST_POP_RD;
              ctx_d   = CTX_POPB;
            end
            default: state_d = ST_PUSH;
          endcase
        end
      end
      ST_POP_RD: state_d = ST_POP_X;
      ST_POP_X:  state_d = ST_SIFT_RD;
      ST_PUSH:   state_d = ST_UP_RD;
      ST_UP_RD: begin
        if (sts_i.up_zero) begin
          state_d = after_merge;
          ctx_d   = CTX_POPA;
        end else begin
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts_i.up_stop) begin
          state_d = after_merge;
          ctx_d   = CTX_POPA;
        end else begin
          state_d = ST_UP_RD;
        end
      end
      ST_ROOT_RD:    state_d = ST_ROOT_X;
      ST_ROOT_X:     state_d = ST_WALK_DEC;
      ST_WALK_DEC:   state_d = sts_i.is_leaf ? ST_WALK_EMIT : ST_WALK_CHILD;
      ST_WALK_CHILD: state_d = ST_WALK_DEC;
      ST_WALK_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.sp_zero ? ST_LOAD : ST_WALK_DEC;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = 1'b1;
        cmd_o.build  = in_accept_i && in_last_i;
      end
      ST_HFY_RD:  cmd_o.hfy_rd = 1'b1;
      ST_HFY_X:   cmd_o.hfy_x  = 1'b1;
      ST_SIFT_RD: cmd_o.sift_rd = 1'b1;
      ST_SIFT_CMP: begin
        cmd_o.sift_cmp = 1'b1;
        cmd_o.hfy_dec  = sts_i.sift_stop && (ctx_q == CTX_HFY) && !sts_i.hfy_zero;
      end
      ST_POP_RD: cmd_o.pop_rd = 1'b1;
      ST_POP_X: begin
        cmd_o.pop_x      = 1'b1;
        cmd_o.pop_second = (ctx_q == CTX_POPB);
      end
      ST_PUSH:       cmd_o.push       = 1'b1;
      ST_UP_RD:      cmd_o.up_rd      = 1'b1;
      ST_UP_CMP:     cmd_o.up_cmp     = 1'b1;
      ST_ROOT_RD:    cmd_o.root_rd    = 1'b1;
      ST_ROOT_X:     cmd_o.root_x     = 1'b1;
      ST_WALK_CHILD: cmd_o.walk_child = 1'b1;
      ST_WALK_EMIT:  cmd_o.walk_emit  = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ctx_q   <= CTX_HFY;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hcb_dp.sv =====
// Datapath: symbol store, min-heap, child links, walk stack and output register.
`timescale 1ns / 1ps
`default_nettype none
module hcb_dp import hcb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic                 in_accept_i,
  input  wire logic [S_TDATA_W-1:0] in_data_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic      [M_TDATA_W-1:0] out_data_o,
  output logic                      out_last_o,
  output logic                      out_drop_o
);

  localparam int unsigned IDX_W      = $clog2(MAX_SYMBOLS);
  localparam int unsigned CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned NODE_SLOTS = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned NODE_W     = $clog2(NODE_SLOTS);
  localparam int unsigned ENT_W      = WEIGHT_W + NODE_W;
  localparam int unsigned STK_W      = CODE_W + LEN_W + NODE_W;

  logic [CNT_W-1:0]  loaded_q, fill_q;
  logic              ovf_q;
  logic [IDX_W-1:0]  hi_q, pos_q, up_q, sp_q;
  logic [ENT_W-1:0]  x_q, a_q, b_q, y_q;
  logic [NODE_W-1:0] next_q;
  logic [NODE_W-1:0] cur_node_q;
  logic [LEN_W-1:0]  cur_len_q;
  logic [CODE_W-1:0] cur_code_q;
  logic              out_valid_q, out_last_q, out_drop_q;
  logic [COLOR_W-1:0] out_color_q;
  logic [CODE_W-1:0] out_code_q;
  logic [LEN_W-1:0]  out_len_q;

  logic [COLOR_W-1:0] in_color;
  logic [COUNT_W-1:0] in_count;
  logic               full, load_wr;
  logic [CNT_W-1:0]   n_new, hfy_start;

  logic              hw_en;
  logic [IDX_W-1:0]  hw_addr, hr_addr_a, hr_addr_b;
  logic [ENT_W-1:0]  hw_data, hr_a, hr_b;

  logic [IDX_W+1:0]  l_wide, r_wide;
  logic              l_ok, r_ok, take_l, take_r, sift_stop, up_stop;
  logic [WEIGHT_W-1:0] best_lw;
  logic [IDX_W-1:0]  best_pos;
  logic [ENT_W-1:0]  best_ent;
  logic [IDX_W-1:0]  parent;

  logic [COLOR_W-1:0]  color_rd;
  logic [2*NODE_W-1:0] child_rd;
  logic [STK_W-1:0]    stk_rd, stk_wdata;
  logic [NODE_W-1:0]   left_node, right_node;
  logic                out_free;

  assign in_color  = in_data_i[COLOR_W-1:0];
  assign in_count  = in_data_i[COLOR_W +: COUNT_W];
  assign full      = (loaded_q == CNT_W'(MAX_SYMBOLS));
  assign load_wr   = cmd_i.load && in_accept_i && !full;
  assign n_new     = full ? loaded_q : loaded_q + CNT_W'(1);
  assign hfy_start = (n_new >= CNT_W'(2)) ? ((n_new - CNT_W'(2)) >> 1) : '0;

  // Sift-down compare: strict less-than, left child tried first.
  assign l_wide   = {1'b0, pos_q, 1'b1};
  assign r_wide   = l_wide + (IDX_W + 2)'(1);
  assign l_ok     = l_wide < (IDX_W + 2)'(fill_q);
  assign r_ok     = r_wide < (IDX_W + 2)'(fill_q);
  assign take_l   = l_ok && (hr_a[ENT_W-1:NODE_W] < x_q[ENT_W-1:NODE_W]);
  assign best_lw  = take_l ? hr_a[ENT_W-1:NODE_W] : x_q[ENT_W-1:NODE_W];
  assign take_r   = r_ok && (hr_b[ENT_W-1:NODE_W] < best_lw);
  assign sift_stop = !take_l && !take_r;
  assign best_pos = take_r ? r_wide[IDX_W-1:0] : l_wide[IDX_W-1:0];
  assign best_ent = take_r ? hr_b : hr_a;

  assign parent  = (up_q - IDX_W'(1)) >> 1;
  assign up_stop = !(y_q[ENT_W-1:NODE_W] < hr_a[ENT_W-1:NODE_W]);

  always_comb begin
    hw_en   = 1'b0;
    hw_addr = '0;
    hw_data = '0;
    if (load_wr) begin
      hw_en   = 1'b1;
      hw_addr = loaded_q[IDX_W-1:0];
      hw_data = {WEIGHT_W'(in_count), NODE_W'(loaded_q)};
    end else if (cmd_i.sift_cmp) begin
      hw_en   = 1'b1;
      hw_addr = pos_q;
      hw_data = sift_stop ? x_q : best_ent;
    end else if (cmd_i.up_rd && (up_q == '0)) begin
      hw_en   = 1'b1;
      hw_data = y_q;
    end else if (cmd_i.up_cmp) begin
      hw_en   = 1'b1;
      hw_addr = up_q;
      hw_data = up_stop ? y_q : hr_a;
    end
  end

  always_comb begin
    hr_addr_a = '0;
    hr_addr_b = '0;
    if (cmd_i.hfy_rd) begin
      hr_addr_a = hi_q;
    end else if (cmd_i.sift_rd) begin
      hr_addr_a = l_wide[IDX_W-1:0];
      hr_addr_b = r_wide[IDX_W-1:0];
    end else if (cmd_i.pop_rd) begin
      hr_addr_b = IDX_W'(fill_q - CNT_W'(1));
    end else if (cmd_i.up_rd) begin
      hr_addr_a = parent;
    end
  end

  // Two copies of the heap give two reads per cycle.
  hcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SYMBOLS)) u_heap_a (
    .clk_i, .we_i(hw_en), .waddr_i(hw_addr), .wdata_i(hw_data),
    .raddr_i(hr_addr_a), .rdata_o(hr_a)
  );

  hcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SYMBOLS)) u_heap_b (
    .clk_i, .we_i(hw_en), .waddr_i(hw_addr), .wdata_i(hw_data),
    .raddr_i(hr_addr_b), .rdata_o(hr_b)
  );

  hcb_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SYMBOLS)) u_color (
    .clk_i, .we_i(load_wr), .waddr_i(loaded_q[IDX_W-1:0]), .wdata_i(in_color),
    .raddr_i(cur_node_q[IDX_W-1:0]), .rdata_o(color_rd)
  );

  hcb_ram #(.WIDTH(2 * NODE_W), .DEPTH(NODE_SLOTS)) u_child (
    .clk_i, .we_i(cmd_i.push), .waddr_i(next_q),
    .wdata_i({a_q[NODE_W-1:0], b_q[NODE_W-1:0]}),
    .raddr_i(cur_node_q), .rdata_o(child_rd)
  );

  assign left_node  = child_rd[2*NODE_W-1:NODE_W];
  assign right_node = child_rd[NODE_W-1:0];
  assign stk_wdata  = {{cur_code_q[CODE_W-2:0], 1'b1}, cur_len_q + LEN_W'(1), right_node};

  hcb_ram #(.WIDTH(STK_W), .DEPTH(MAX_SYMBOLS)) u_stack (
    .clk_i, .we_i(cmd_i.walk_child), .waddr_i(sp_q), .wdata_i(stk_wdata),
    .raddr_i(sp_q - IDX_W'(1)), .rdata_o(stk_rd)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_accept_i) begin
        loaded_q <= n_new;
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.build) begin
        fill_q <= n_new;
      end else if (cmd_i.pop_x) begin
        fill_q <= fill_q - CNT_W'(1);
      end else if (cmd_i.push) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (cmd_i.walk_emit) begin
        out_valid_q <= 1'b1;
        if (sp_q == '0) begin
          loaded_q <= '0;
          fill_q   <= '0;
          ovf_q    <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build) begin
      hi_q   <= hfy_start[IDX_W-1:0];
      next_q <= NODE_W'(n_new);
    end
    if (cmd_i.hfy_dec) begin
      hi_q <= hi_q - IDX_W'(1);
    end
    if (cmd_i.hfy_rd) begin
      pos_q <= hi_q;
    end
    if (cmd_i.hfy_x) begin
      x_q <= hr_a;
    end
    if (cmd_i.sift_cmp && !sift_stop) begin
      pos_q <= best_pos;
    end
    // Pop: keep the top, move the tail entry down from the root.
    if (cmd_i.pop_x) begin
      if (cmd_i.pop_second) begin
        b_q <= hr_a;
      end else begin
        a_q <= hr_a;
      end
      x_q   <= hr_b;
      pos_q <= '0;
    end
    if (cmd_i.push) begin
      y_q    <= {a_q[ENT_W-1:NODE_W] + b_q[ENT_W-1:NODE_W], next_q};
      next_q <= next_q + NODE_W'(1);
      up_q   <= fill_q[IDX_W-1:0];
    end
    if (cmd_i.up_cmp && !up_stop) begin
      up_q <= parent;
    end
    if (cmd_i.root_x) begin
      cur_node_q <= hr_a[NODE_W-1:0];
      cur_len_q  <= '0;
      cur_code_q <= '0;
      sp_q       <= '0;
    end
    // Right child waits on the stack, left child is taken next.
    if (cmd_i.walk_child) begin
      cur_node_q <= left_node;
      cur_len_q  <= cur_len_q + LEN_W'(1);
      cur_code_q <= {cur_code_q[CODE_W-2:0], 1'b0};
      sp_q       <= sp_q + IDX_W'(1);
    end
    if (cmd_i.walk_emit) begin
      out_color_q <= color_rd;
      out_code_q  <= cur_code_q;
      out_len_q   <= cur_len_q;
      out_last_q  <= (sp_q == '0);
      out_drop_q  <= ovf_q;
      if (sp_q != '0) begin
        {cur_code_q, cur_len_q, cur_node_q} <= stk_rd;
        sp_q <= sp_q - IDX_W'(1);
      end
    end
  end

  assign sts_o.hfy_zero  = (hi_q == '0);
  assign sts_o.fill_gt1  = (fill_q > CNT_W'(1));
  assign sts_o.sift_stop = sift_stop;
  assign sts_o.up_zero   = (up_q == '0);
  assign sts_o.up_stop   = up_stop;
  assign sts_o.is_leaf   = {1'b0, cur_node_q} < (NODE_W + 1)'(loaded_q);
  assign sts_o.sp_zero   = (sp_q == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, out_len_q, out_code_q, out_color_q};
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;

endmodule
`default_nettype wire

// ===== rtl/core/huffman_code_builder_core.sv =====
// Top level of the Huffman code builder: controller plus datapath.
//
//   channel   dir  fields (tdata from bit 0 up)                 tlast        tuser
//   s_axis    in   symbol_color[23:0] symbol_count[47:24]       last_symbol  -
//   m_axis    out  code_color[23:0] code_bits[87:24]            last_code    dropped_symbols
//                  code_length[93:88]
//
// Loading accepts one symbol per cycle. After the last symbol the build runs with input
// stalled: heapify and every pop read and take an entry, then sift it down with one heap
// read and one compare and write per heap level; a push writes the new node and sifts it
// up the same way. The walk decodes each tree node, then descends or emits a code.
// No clearing pass after reset. A stalled m_axis holds the walk at the next leaf.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_core import hcb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // symbol_color[23:0], symbol_count[47:24]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // code_color[23:0], code_bits[87:24], code_length[93:88], zero fill
  output logic      [M_TDATA_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  // dropped_symbols[0]
  output logic                      m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  hcb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_accept_i (in_accept),
    .in_last_i   (s_axis_tlast),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_accept_i (in_accept),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_drop_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hcb_checker.sv =====
// Port-level checks of the code builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_builder_core_macros.svh"
module hcb_checker import hcb_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tlast,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  `HCB_ASSERT(a_build_stalls_input, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "input taken right after last symbol")
  `HCB_ASSERT_NEVER(a_code_mid_run_while_loading, $rose(m_axis_tvalid) && !m_axis_tlast && s_axis_tready, "code mid-run while loading")
  `HCB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled code item changed")

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .s_axis_tlast,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .m_axis_tlast
);
`default_nettype wire

// ===== tb/sv/tb_huffman_code_builder_core.sv =====
// Testbench for the Huffman code builder: stream stimulus, heap predictor, code check.
`timescale 1ns / 1ps
module tb_huffman_code_builder_core;
  import hcb_pkg::*;

  localparam int CAP       = 64;
  localparam int NODES     = 2 * CAP - 1;
  localparam int IDLE_MAX  = 20000;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [CODE_W-1:0]  bits;
    logic [LEN_W-1:0]   len;
    logic               last;
    logic               drop;
  } code_t;

  class code_scoreboard;
    logic [COLOR_W-1:0]  colors[CAP];
    logic [WEIGHT_W-1:0] weight[NODES];
    int                  lch[NODES];
    int                  rch[NODES];
    int                  heap[CAP];
    int                  fill;
    int                  loaded;
    bit                  over;
    code_t               pending[$];
    int                  errors;
    int                  sets;
    int                  codes;

    function logic [WEIGHT_W-1:0] wt(int slot);
      return weight[heap[slot % CAP] % NODES];
    endfunction

    function void sift_down(int pos);
      int best, l, r, t;
      forever begin
        best = pos;
        l = 2 * pos + 1;
        r = 2 * pos + 2;
        if (l < fill && wt(l) < wt(best)) best = l;
        if (r < fill && wt(r) < wt(best)) best = r;
        if (best == pos) return;
        t = heap[best];
        heap[best] = heap[pos];
        heap[pos] = t;
        pos = best;
      end
    endfunction

    function int pop_min();
      int top;
      top = heap[0];
      if (fill == 0) return top;
      heap[0] = heap[(fill - 1) % CAP];
      fill--;
      sift_down(0);
      return top;
    endfunction

    function void push_node(int node);
      int i;
      if (fill >= CAP) return;
      fill++;
      i = fill - 1;
      while (i != 0 && weight[node % NODES] < wt((i - 1) / 2)) begin
        heap[i] = heap[(i - 1) / 2];
        i = (i - 1) / 2;
      end
      heap[i] = node;
    endfunction

    function void build_codes();
      int n, i, nxt, a, b, root, sp, cur_len, node, d, keep, emitted;
      int stk[CAP];
      int dep[CAP];
      bit bitv[CAP];
      logic [CODE_W-1:0] path, prefix;
      code_t c;
      n = loaded;
      emitted = 0;
      for (i = 0; i < n; i++) heap[i] = i;
      fill = n;
      i = (n >= 2) ? (n - 2) / 2 : 0;
      forever begin
        sift_down(i);
        if (i == 0) break;
        i--;
      end
      nxt = n;
      while (fill > 1 && nxt < NODES) begin
        a = pop_min();
        b = pop_min();
        weight[nxt] = weight[a % NODES] + weight[b % NODES];
        lch[nxt] = a;
        rch[nxt] = b;
        push_node(nxt);
        nxt++;
      end
      root = pop_min();
      path = '0;
      cur_len = 0;
      stk[0] = root;
      dep[0] = 0;
      bitv[0] = 0;
      sp = 1;
      while (sp > 0) begin
        sp--;
        node = stk[sp] % NODES;
        d = dep[sp];
        if (d > 0) begin
          keep = d - 1;
          prefix = (cur_len > keep) ? (path >> (cur_len - keep)) : path;
          path = (prefix << 1) | CODE_W'(bitv[sp]);
          cur_len = d;
        end
        if (node < n) begin
          if (emitted < CAP) begin
            c.color = colors[node % CAP];
            c.bits  = (cur_len == 0) ? '0 : path;
            c.len   = LEN_W'(cur_len);
            c.last  = 1'b0;
            c.drop  = over;
            pending.push_back(c);
            emitted++;
          end
        end else if (sp + 2 <= CAP && d < 63) begin
          stk[sp] = rch[node];
          dep[sp] = d + 1;
          bitv[sp] = 1;
          sp++;
          stk[sp] = lch[node];
          dep[sp] = d + 1;
          bitv[sp] = 0;
          sp++;
        end
      end
      if (emitted > 0) pending[pending.size() - 1].last = 1'b1;
      loaded = 0;
      fill = 0;
      over = 0;
      sets++;
    endfunction

    function void note_symbol(logic [COLOR_W-1:0] color, logic [COUNT_W-1:0] count,
                              logic last);
      if (loaded < CAP) begin
        colors[loaded] = color;
        weight[loaded] = WEIGHT_W'(count);
        loaded++;
      end else begin
        over = 1;
      end
      if (last) build_codes();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_code(code_t got);
      code_t exp_c;
      codes++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected code color=%h", got.color));
        return;
      end
      exp_c = pending.pop_front();
      if (got.color !== exp_c.color)
        report($sformatf("color %h, want %h", got.color, exp_c.color));
      if (got.bits !== exp_c.bits)
        report($sformatf("bits %h, want %h (color %h)", got.bits, exp_c.bits, exp_c.color));
      if (got.len !== exp_c.len)
        report($sformatf("length %0d, want %0d (color %h)", got.len, exp_c.len, exp_c.color));
      if (got.last !== exp_c.last)
        report($sformatf("last %b, want %b (color %h)", got.last, exp_c.last, exp_c.color));
      if (got.drop !== exp_c.drop)
        report($sformatf("dropped %b, want %b (color %h)", got.drop, exp_c.drop, exp_c.color));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  code_scoreboard sb = new();
  bit hold_req = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  huffman_code_builder_core #(.MAX_SYMBOLS(CAP)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe both sides; values read here are the ones from before the edge.
  always @(posedge clk_i) begin
    code_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_symbol(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.color = m_axis_tdata[23:0];
        got.bits  = m_axis_tdata[87:24];
        got.len   = m_axis_tdata[93:88];
        got.last  = m_axis_tlast;
        got.drop  = m_axis_tuser;
        sb.check_code(got);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("watchdog: no progress for %0d cycles", IDLE_MAX);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: mostly ready, short random stalls, rare long ones, one forced hold-off.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Hold from the first code of the set on, so the walk backs up.
        m_axis_tready <= 1'b0;
        while (!m_axis_tvalid) @(posedge clk_i);
        repeat (600) @(posedge clk_i);
        hold_req = 0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:1]:   stall = $urandom_range(20, 80);
          [2:24]:  stall = $urandom_range(0, 3);
          default: stall = 0;
        endcase
        m_axis_tready <= (stall == 0);
      end
    end
  end

  task automatic send_symbol(logic [COLOR_W-1:0] color, logic [COUNT_W-1:0] count,
                             logic last, bit burst);
    int gap;
    gap = 0;
    if (!burst) begin
      case ($urandom_range(0, 99)) inside
        [0:2]:   gap = $urandom_range(10, 40);
        [3:39]:  gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {count, color};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Send one set; tie-heavy sets draw counts from a narrow range.
  task automatic send_set(int size, bit ties, bit burst);
    logic [COUNT_W-1:0] count;
    for (int i = 0; i < size; i++) begin
      if (ties) count = COUNT_W'($urandom_range(0, 3));
      else if ($urandom_range(0, 3) == 0) count = COUNT_W'($urandom);
      else count = COUNT_W'($urandom_range(0, 1000));
      send_symbol(COLOR_W'($urandom), count, i == size - 1, burst);
    end
  endtask

  // Drop the input, wait for an edge so the last accepted item is noted first, then wait until no code is pending.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lone symbol at the extremes of both fields.
    send_symbol(24'hFFFFFF, 24'hFFFFFF, 1'b1, 0);
    send_symbol(24'h000000, 24'h000000, 1'b1, 0);
    // Zero against maximum count.
    send_symbol(24'h123456, 24'h000000, 1'b0, 0);
    send_symbol(24'hFEDCBA, 24'hFFFFFF, 1'b1, 0);
    // Equal counts: ties keep heap order.
    for (int i = 0; i < 4; i++) send_symbol(COLOR_W'(24'hA0 + i), 24'd7, i == 3, 0);
    // Skewed counts give a deep tree.
    for (int i = 0; i < 8; i++) send_symbol(COLOR_W'(24'h800000 | i), COUNT_W'(1 << (2 * i)),
                                            i == 7, 0);
    wait_drained();

    // Random small sets, all well formed with random content.
    for (int s = 0; s < 25; s++) send_set($urandom_range(1, 8), $urandom_range(0, 2) == 0, 0);
    wait_drained();

    // Full set with receiver held off while the next set is offered behind it.
    hold_req = 1;
    send_set(CAP, 0, 1);
    send_set(6, 0, 1);
    wait_drained();

    // Overflow where the dropped symbol is the one marked last.
    send_set(CAP + 1, 1, 0);
    wait_drained();
    // Overflow with several drops before the last one.
    send_set(CAP + 3, 0, 0);

    while (items_sent < 410) send_set($urandom_range(1, 10), $urandom_range(0, 3) == 0,
                                      $urandom_range(0, 4) == 0);
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("run: %0d symbols in %0d sets, %0d codes checked", items_sent, sb.sets, sb.codes);
    $display("covered lone, tied, skewed, full and overflowing sets under stalls on both sides");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== huffman_code_builder_core.f =====
+incdir+rtl/core
rtl/core/hcb_pkg.sv
rtl/core/hcb_ram.sv
rtl/core/hcb_ctrl.sv
rtl/core/hcb_dp.sv
rtl/core/huffman_code_builder_core.sv
rtl/core/hcb_checker.sv
tb/sv/tb_huffman_code_builder_core.sv
